// File: rtl/core/php_pkg.sv
// Shared types, constants and register codes for the position-hold PD controller.
`timescale 1ns / 1ps
package php_pkg;

   localparam int unsigned MS_TO_US       = 1000;
   localparam int unsigned WINDOW_WIDTH   = 26;
   localparam int unsigned CSR_IDX_WIDTH  = 3;
   localparam int unsigned CSR_DATA_WIDTH = 31;
   localparam int unsigned PROD_WIDTH     = 50;
   localparam int unsigned SUM_WIDTH      = 52;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic ACTION_COMMAND = 1'b0;
   localparam logic ACTION_SAMPLE  = 1'b1;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_VEL_BOUND = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IQ_BOUND  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KP_MIN    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KP_MAX    = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KD_MIN    = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KD_MAX    = 3'd5;

   localparam logic [30:0] VEL_BOUND_RESET = 31'd6553600;
   localparam logic [30:0] IQ_BOUND_RESET  = 31'd131072;
   localparam logic [15:0] KP_MIN_RESET    = 16'd0;
   localparam logic [15:0] KP_MAX_RESET    = 16'd2560;
   localparam logic [15:0] KD_MIN_RESET    = 16'd0;
   localparam logic [15:0] KD_MAX_RESET    = 16'd256;

   typedef struct packed {
      logic [30:0] vel_bound;
      logic [30:0] iq_bound;
      logic [15:0] kp_min;
      logic [15:0] kp_max;
      logic [15:0] kd_min;
      logic [15:0] kd_max;
   } cfg_type;

   // Classified queue item; velocity, feedforward and gains already clamped.
   typedef struct packed {
      logic                    action;
      logic [31:0]             time_us;
      logic [31:0]             target_position;
      logic [31:0]             target_velocity;
      logic [31:0]             feedforward;
      logic [15:0]             kp;
      logic [15:0]             kd;
      logic [WINDOW_WIDTH-1:0] window_us;
      logic                    motor_enable;
      logic [31:0]             measured_angle;
      logic [31:0]             measured_velocity;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic                  is_command;
      logic                  run;
      logic                  torque_active;
      logic                  expired;
      logic [PROD_WIDTH-1:0] p_prod;
      logic [PROD_WIDTH-1:0] v_prod;
      logic [31:0]           feedforward;
   } stage_type;

endpackage

// File: rtl/core/php_front.sv
// Front end: takes items, clamps velocity/current/gains, forms queue entry.
`timescale 1ns / 1ps
module php_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [31:0]               req_time_us,
   input  logic signed [31:0]        req_target_position,
   input  logic signed [31:0]        req_target_velocity,
   input  logic signed [31:0]        req_feedforward_current,
   input  logic [15:0]               req_gain_kp,
   input  logic [15:0]               req_gain_kd,
   input  logic [15:0]               req_timeout_ms,
   input  logic                      req_motor_enable,
   input  logic signed [31:0]        req_measured_angle,
   input  logic signed [31:0]        req_measured_velocity,
   input  php_pkg::cfg_type          cfg,
   input  php_pkg::queue_status_type q_status,
   output logic                      push,
   output php_pkg::item_type         push_item
);

   function automatic logic [31:0] clamp_sym(input logic [31:0] v, input logic [30:0] lim);
      logic signed [32:0] sv;
      logic signed [32:0] pos;
      logic signed [32:0] neg;
      logic signed [32:0] res;
      sv  = $signed({v[31], v});
      pos = $signed({2'b00, lim});
      neg = -pos;
      if (sv < neg) begin
         res = neg;
      end else if (sv > pos) begin
         res = pos;
      end else begin
         res = sv;
      end
      return res[31:0];
   endfunction

   function automatic logic [15:0] clamp_gain(input logic [15:0] v, input logic [15:0] lo,
                                              input logic [15:0] hi);
      logic [15:0] res;
      if (v < lo) begin
         res = lo;
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_item.action            = req_action;
      push_item.time_us           = req_time_us;
      push_item.target_position   = req_target_position;
      push_item.target_velocity   = clamp_sym(req_target_velocity, cfg.vel_bound);
      push_item.feedforward       = clamp_sym(req_feedforward_current, cfg.iq_bound);
      push_item.kp                = clamp_gain(req_gain_kp, cfg.kp_min, cfg.kp_max);
      push_item.kd                = clamp_gain(req_gain_kd, cfg.kd_min, cfg.kd_max);
      push_item.window_us         = php_pkg::WINDOW_WIDTH'(req_timeout_ms)
                                  * php_pkg::WINDOW_WIDTH'(php_pkg::MS_TO_US);
      push_item.motor_enable      = req_motor_enable;
      push_item.measured_angle    = req_measured_angle;
      push_item.measured_velocity = req_measured_velocity;
   end

endmodule

// File: rtl/core/php_queue.sv
// Small FIFO between the front end and the control back end.
`timescale 1ns / 1ps
module php_queue #(
   parameter int unsigned DEPTH = php_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  php_pkg::item_type         push_item,
   input  logic                      pop,
   output php_pkg::item_type         head_item,
   output php_pkg::queue_status_type q_status
);

   localparam int unsigned PTR_WIDTH = $clog2(DEPTH);
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

   php_pkg::item_type      entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic [CNT_WIDTH-1:0]   count_in;

   assign head_item      = entries_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_FULL);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
         end
      end
   end

endmodule

// File: rtl/core/php_back.sv
// Back end: held reference, watchdog, PD products, sum and saturation, result register.
`timescale 1ns / 1ps
module php_back (
   input  logic                      clock,
   input  logic                      reset,
   input  php_pkg::cfg_type          cfg,
   input  php_pkg::item_type         head_item,
   input  php_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_iq_command,
   output logic                      rsp_torque_active,
   output logic                      rsp_watchdog_expired
);

   localparam int unsigned PW = php_pkg::PROD_WIDTH;
   localparam int unsigned SW = php_pkg::SUM_WIDTH;

   logic [31:0]                      held_pos_ff;
   logic [31:0]                      held_vel_ff;
   logic [31:0]                      held_ff_ff;
   logic [15:0]                      held_kp_ff;
   logic [15:0]                      held_kd_ff;
   logic [31:0]                      last_time_ff;
   logic [php_pkg::WINDOW_WIDTH-1:0] window_ff;
   logic                             torque_en_ff;
   logic                             motor_on_ff;

   php_pkg::stage_type s1_ff;
   php_pkg::stage_type s1_in;
   logic               s1_valid_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_iq_ff;   // doubles as last_iq
   logic               rsp_torque_ff;
   logic               rsp_expired_ff;

   logic               adv_out;
   logic               s1_free;
   logic               is_command;
   logic [31:0]        elapsed;
   logic               lapsed;
   logic               expire;
   logic signed [32:0] perr;
   logic signed [32:0] verr;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] lim_pos;
   logic signed [SW-1:0] lim_neg;
   logic signed [SW-1:0] sat;
   logic signed [31:0]   iq_next;

   assign adv_out = !rsp_valid_ff || !rsp_stall;
   assign s1_free = !s1_valid_ff || adv_out;
   assign pop     = !q_status.empty && s1_free;

   assign is_command = (head_item.action == php_pkg::ACTION_COMMAND);
   assign elapsed    = head_item.time_us - last_time_ff;
   assign lapsed     = (window_ff != '0) && (elapsed > {6'b0, window_ff});
   assign expire     = !is_command && torque_en_ff && lapsed;
   assign perr       = $signed({held_pos_ff[31], held_pos_ff})
                     - $signed({head_item.measured_angle[31], head_item.measured_angle});
   assign verr       = $signed({held_vel_ff[31], held_vel_ff})
                     - $signed({head_item.measured_velocity[31], head_item.measured_velocity});

   always_comb begin
      s1_in.is_command    = is_command;
      s1_in.run           = torque_en_ff && !lapsed && motor_on_ff;
      s1_in.expired       = expire;
      s1_in.torque_active = is_command ? head_item.motor_enable
                                       : (torque_en_ff && motor_on_ff && !expire);
      s1_in.p_prod        = PW'($signed({1'b0, held_kp_ff})) * PW'(perr);
      s1_in.v_prod        = PW'($signed({1'b0, held_kd_ff})) * PW'(verr);
      s1_in.feedforward   = held_ff_ff;
   end

   // Q28.24 sum, saturated, then floor to Q16.16 by dropping 8 bits
   always_comb begin
      sum = $signed({{(SW-PW){s1_ff.p_prod[PW-1]}}, s1_ff.p_prod})
          + $signed({{(SW-PW){s1_ff.v_prod[PW-1]}}, s1_ff.v_prod})
          + $signed({{(SW-40){s1_ff.feedforward[31]}}, s1_ff.feedforward, 8'b0});
      lim_pos = $signed({{(SW-39){1'b0}}, cfg.iq_bound, 8'b0});
      lim_neg = -lim_pos;
      if (sum > lim_pos) begin
         sat = lim_pos;
      end else if (sum < lim_neg) begin
         sat = lim_neg;
      end else begin
         sat = sum;
      end
      if (s1_ff.is_command) begin
         iq_next = rsp_iq_ff;
      end else if (s1_ff.run) begin
         iq_next = sat[39:8];
      end else begin
         iq_next = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_pos_ff    <= '0;
         held_vel_ff    <= '0;
         held_ff_ff     <= '0;
         held_kp_ff     <= '0;
         held_kd_ff     <= '0;
         last_time_ff   <= '0;
         window_ff      <= '0;
         torque_en_ff   <= 1'b0;
         motor_on_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_iq_ff      <= '0;
         rsp_torque_ff  <= 1'b0;
         rsp_expired_ff <= 1'b0;
      end else begin
         if (pop) begin
            s1_valid_ff <= 1'b1;
            if (is_command) begin
               last_time_ff <= head_item.time_us;
               window_ff    <= head_item.window_us;
               torque_en_ff <= 1'b1;
               motor_on_ff  <= head_item.motor_enable;
               if (head_item.motor_enable) begin
                  held_pos_ff <= head_item.target_position;
                  held_vel_ff <= head_item.target_velocity;
                  held_ff_ff  <= head_item.feedforward;
                  held_kp_ff  <= head_item.kp;
                  held_kd_ff  <= head_item.kd;
               end
            end else if (expire) begin
               torque_en_ff <= 1'b0;
               motor_on_ff  <= 1'b0;
            end
         end else if (adv_out) begin
            s1_valid_ff <= 1'b0;
         end
         if (adv_out) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               rsp_iq_ff      <= iq_next;
               rsp_torque_ff  <= s1_ff.torque_active;
               rsp_expired_ff <= s1_ff.expired;
            end
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_iq_command       = rsp_iq_ff;
   assign rsp_torque_active    = rsp_torque_ff;
   assign rsp_watchdog_expired = rsp_expired_ff;

endmodule

// File: rtl/core/position_hold_pd_with_command_watchdog_top.sv
// Top level: position-hold PD loop with feedforward and command watchdog for one motor.
//
// Usage: items enter on the req_ channel (req_action low = reference command, high =
// control sample tick) and each produces exactly one result on the rsp_ channel,
// in order. A transfer happens on a clock edge with valid high and stall low.
// Limits and gain bounds are written through csr_we/csr_index/csr_wdata while idle.
// Path: a result passes through the queue entry written on acceptance, then the
// watchdog and PD product register, then the sum/saturate result register; a
// receiver stall can hold it between them.
// Throughput: one item per cycle sustained while rsp_stall stays low; the back end
// takes one queue entry per cycle, the two gain products sharing one register stage.
// The front end writes into a QUEUE_DEPTH-entry FIFO; req_stall rises only when
// the FIFO is full.
// Receiver stall: the result register holds, the product stage freezes, and
// incoming items collect in the FIFO until it fills.
// Reset (synchronous, active high): registers return to their default limits and
// bounds, the held reference, timer and last current clear, torque is disabled
// and the FIFO empties. No clearing pass is needed; items are accepted the cycle
// after reset drops.
`timescale 1ns / 1ps
module position_hold_pd_with_command_watchdog_top #(
   parameter int unsigned QUEUE_DEPTH = php_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [31:0]                         req_time_us,
   input  logic signed [31:0]                  req_target_position,
   input  logic signed [31:0]                  req_target_velocity,
   input  logic signed [31:0]                  req_feedforward_current,
   input  logic [15:0]                         req_gain_kp,
   input  logic [15:0]                         req_gain_kd,
   input  logic [15:0]                         req_timeout_ms,
   input  logic                                req_motor_enable,
   input  logic signed [31:0]                  req_measured_angle,
   input  logic signed [31:0]                  req_measured_velocity,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_iq_command,
   output logic                                rsp_torque_active,
   output logic                                rsp_watchdog_expired,
   input  logic                                csr_we,
   input  logic [php_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [php_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   php_pkg::cfg_type          cfg_ff;
   php_pkg::item_type         push_item;
   php_pkg::item_type         head_item;
   php_pkg::queue_status_type q_status;
   logic                      q_push;
   logic                      q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vel_bound <= php_pkg::VEL_BOUND_RESET;
         cfg_ff.iq_bound  <= php_pkg::IQ_BOUND_RESET;
         cfg_ff.kp_min    <= php_pkg::KP_MIN_RESET;
         cfg_ff.kp_max    <= php_pkg::KP_MAX_RESET;
         cfg_ff.kd_min    <= php_pkg::KD_MIN_RESET;
         cfg_ff.kd_max    <= php_pkg::KD_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            php_pkg::CSR_VEL_BOUND: cfg_ff.vel_bound <= csr_wdata;
            php_pkg::CSR_IQ_BOUND:  cfg_ff.iq_bound  <= csr_wdata;
            php_pkg::CSR_KP_MIN:    cfg_ff.kp_min    <= csr_wdata[15:0];
            php_pkg::CSR_KP_MAX:    cfg_ff.kp_max    <= csr_wdata[15:0];
            php_pkg::CSR_KD_MIN:    cfg_ff.kd_min    <= csr_wdata[15:0];
            php_pkg::CSR_KD_MAX:    cfg_ff.kd_max    <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   php_front u_front (
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_action              (req_action),
      .req_time_us             (req_time_us),
      .req_target_position     (req_target_position),
      .req_target_velocity     (req_target_velocity),
      .req_feedforward_current (req_feedforward_current),
      .req_gain_kp             (req_gain_kp),
      .req_gain_kd             (req_gain_kd),
      .req_timeout_ms          (req_timeout_ms),
      .req_motor_enable        (req_motor_enable),
      .req_measured_angle      (req_measured_angle),
      .req_measured_velocity   (req_measured_velocity),
      .cfg                     (cfg_ff),
      .q_status                (q_status),
      .push                    (q_push),
      .push_item               (push_item)
   );

   php_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   php_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head_item            (head_item),
      .q_status             (q_status),
      .pop                  (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_iq_command       (rsp_iq_command),
      .rsp_torque_active    (rsp_torque_active),
      .rsp_watchdog_expired (rsp_watchdog_expired)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");

   a_expired_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_watchdog_expired) |-> (rsp_iq_command == '0 && !rsp_torque_active))
      else $error("expired item with current or torque");

endmodule
